### design/psort_pkg.sv
package psort_pkg;

  // store depth and stored coordinate width
  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 32;
  // fill counter must hold MAX_POINTS itself
  localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
  localparam int PORT_BITS  = 32;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // one stored point with its occupancy bit
  typedef struct packed {
    logic   valid;
    coord_t x;
    coord_t y;
  } pt_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic   ins;
    logic   drain;
    coord_t px;
    coord_t py;
  } ctl_t;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } st_t;

endpackage

### design/point_sorter_x_asc_y_desc_top.sv
// channel   | handshake                  | payload
// ----------+----------------------------+-------------------------------------
// input     | start, busy (taken when    | in_px, in_py, in_set_end
//           | start && !busy)            |
// result    | out_valid strobe, 1 cycle  | out_sx, out_sy, out_end, out_dropped
//
// points enter one per cycle while collecting; each that finds room is inserted
// in its sorted place in the cell row in that same cycle, else it is dropped
// a transaction with in_set_end starts a drain of the n stored points, one
// result per cycle; busy is high for the whole drain
// synchronous active-low reset clears the cell valid bits, fill count and flag
// results cannot be stalled; out_valid is a one-cycle strobe per result
module point_sorter_x_asc_y_desc_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_px,
  input  logic [31:0] in_py,
  input  logic        in_set_end,
  output logic        out_valid,
  output logic [31:0] out_sx,
  output logic [31:0] out_sy,
  output logic        out_end,
  output logic        out_dropped
);

  localparam int N = psort_pkg::MAX_POINTS;

  psort_pkg::st_t                      state_r;
  psort_pkg::st_t                      state_nxt;
  logic [psort_pkg::CNT_BITS-1:0]      fill_r;
  logic [psort_pkg::CNT_BITS-1:0]      fill_nxt;
  logic                                overflow_r;
  logic                                overflow_nxt;
  logic                                accept;
  logic                                has_room;
  logic                                last_out;
  psort_pkg::ctl_t                     ctl;
  psort_pkg::pt_t                      cell_pt [N];
  logic                                cell_before [N];

  assign accept   = start && !busy;
  assign has_room = fill_r < psort_pkg::CNT_BITS'(N);

  // broadcast of the incoming point; all input bits are used, as COORD_BITS is 32
  assign ctl.ins   = accept && has_room;
  assign ctl.drain = (state_r == psort_pkg::ST_DRAIN);
  assign ctl.px    = psort_pkg::coord_t'(in_px[psort_pkg::COORD_BITS-1:0]);
  assign ctl.py    = psort_pkg::coord_t'(in_py[psort_pkg::COORD_BITS-1:0]);

  // insertion row: cell 0 holds the first point in sorted order
  for (genvar i = 0; i < N; i++) begin : g_cell
    psort_pkg::pt_t left_pt;
    psort_pkg::pt_t right_pt;
    logic           left_bf;

    if (i == 0) begin : g_first
      assign left_pt = '0;
      assign left_bf = 1'b0;
    end else begin : g_mid
      assign left_pt = cell_pt[i-1];
      assign left_bf = cell_before[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_pt = '0;
    end else begin : g_inner
      assign right_pt = cell_pt[i+1];
    end

    psort_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left        (left_pt),
      .left_before (left_bf),
      .right       (right_pt),
      .own         (cell_pt[i]),
      .ahead       (cell_before[i])
    );
  end

  // head of the row goes out during drain; end when nothing follows it
  assign last_out    = !cell_pt[1].valid;
  assign out_valid   = ctl.drain;
  assign out_sx      = psort_pkg::PORT_BITS'(cell_pt[0].x);
  assign out_sy      = psort_pkg::PORT_BITS'(cell_pt[0].y);
  assign out_end     = last_out;
  assign out_dropped = overflow_r;
  assign busy        = ctl.drain;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= psort_pkg::ST_COLLECT;
      fill_r     <= '0;
      overflow_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      overflow_r <= overflow_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    overflow_nxt = overflow_r;
    unique case (state_r)
      psort_pkg::ST_COLLECT: begin
        if (accept) begin
          if (has_room) begin
            fill_nxt = fill_r + psort_pkg::CNT_BITS'(1);
          end else begin
            overflow_nxt = 1'b1;
          end
          if (in_set_end) begin
            state_nxt = psort_pkg::ST_DRAIN;
          end
        end
      end
      psort_pkg::ST_DRAIN: begin
        // set boundary: next set starts empty and without the flag
        if (last_out) begin
          state_nxt    = psort_pkg::ST_COLLECT;
          fill_nxt     = '0;
          overflow_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = psort_pkg::ST_COLLECT;
      end
    endcase
  end

  // a closing transaction always produces a burst
  a_end_drains: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_set_end |=> out_valid)
    else $error("set end did not start a drain");

  // the burst ends on the result marked end
  a_end_releases: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end |=> !busy && (fill_r == '0) && !overflow_r)
    else $error("drain did not close the set");

  // every result comes from an occupied cell
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cell_pt[0].valid)
    else $error("result from empty cell");

  // fill count never passes the row length
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= psort_pkg::CNT_BITS'(N))
    else $error("fill count overrun");

  // a transaction that finds the row full raises the flag
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !has_room |=> overflow_r)
    else $error("overflow not flagged");

endmodule

### design/psort_cell.sv
module psort_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  psort_pkg::ctl_t  ctl,
  input  psort_pkg::pt_t   left,
  input  logic             left_before,
  input  psort_pkg::pt_t   right,
  output psort_pkg::pt_t   own,
  output logic             ahead
);

  psort_pkg::pt_t own_r;
  psort_pkg::pt_t own_nxt;
  logic           goes_first;

  assign own = own_r;

  // new point sorts ahead of the held one: x ascending, then y descending
  assign goes_first = (ctl.px < own_r.x) || ((ctl.px == own_r.x) && (ctl.py > own_r.y));
  assign ahead      = !own_r.valid || goes_first;

  always_comb begin
    own_nxt = own_r;
    if (ctl.drain) begin
      own_nxt = right;
    end else if (ctl.ins && ahead) begin
      if (left_before) begin
        own_nxt = left;
      end else begin
        own_nxt = '{valid: 1'b1, x: ctl.px, y: ctl.py};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r.valid <= 1'b0;
    end else begin
      own_r <= own_nxt;
    end
  end

endmodule

### dv/point_sorter_checker.sv
module point_sorter_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] in_px,
  input  logic [31:0] in_py,
  input  logic        in_set_end,
  input  logic        out_valid,
  input  logic [31:0] out_sx,
  input  logic [31:0] out_sy,
  input  logic        out_end,
  input  logic        out_dropped,
  output int          fail_count,
  output int          due_count,
  output int          result_count
);

  typedef struct {
    logic [31:0] sx;
    logic [31:0] sy;
    logic        last;
    logic        drop;
  } sorted_pt_t;

  // points of the set being collected
  psort_pkg::coord_t set_x [psort_pkg::MAX_POINTS];
  psort_pkg::coord_t set_y [psort_pkg::MAX_POINTS];
  int                set_fill;
  logic              set_overflow;
  sorted_pt_t        sorted_due [$];
  int                errs;
  int                seen;

  // x ascending, ties by y descending
  function automatic bit goes_first(psort_pkg::coord_t ax, psort_pkg::coord_t ay,
                                    psort_pkg::coord_t bx, psort_pkg::coord_t by);
    if (ax != bx) return ax < bx;
    return ay > by;
  endfunction

  task automatic take_point(logic [31:0] px, logic [31:0] py, logic last);
    psort_pkg::coord_t  kx;
    psort_pkg::coord_t  ky;
    int                 j;
    logic signed [31:0] wide_x;
    logic signed [31:0] wide_y;
    sorted_pt_t         pt;
    if (set_fill < psort_pkg::MAX_POINTS) begin
      set_x[set_fill] = px[psort_pkg::COORD_BITS-1:0];
      set_y[set_fill] = py[psort_pkg::COORD_BITS-1:0];
      set_fill++;
    end else begin
      set_overflow = 1'b1;
    end
    if (!last) return;
    for (int i = 1; i < set_fill; i++) begin
      kx = set_x[i];
      ky = set_y[i];
      j  = i;
      while (j > 0 && goes_first(kx, ky, set_x[j-1], set_y[j-1])) begin
        set_x[j] = set_x[j-1];
        set_y[j] = set_y[j-1];
        j--;
      end
      set_x[j] = kx;
      set_y[j] = ky;
    end
    for (int k = 0; k < set_fill; k++) begin
      wide_x  = set_x[k];
      wide_y  = set_y[k];
      pt.sx   = wide_x;
      pt.sy   = wide_y;
      pt.last = (k == set_fill - 1);
      pt.drop = set_overflow;
      sorted_due.push_back(pt);
    end
    set_fill     = 0;
    set_overflow = 1'b0;
  endtask

  task automatic check_result();
    sorted_pt_t pt;
    seen++;
    if (sorted_due.size() == 0) begin
      errs++;
      $display("%0t: unexpected result, expected none, got x=%0d y=%0d end=%0b drop=%0b",
               $time, $signed(out_sx), $signed(out_sy), out_end, out_dropped);
      return;
    end
    pt = sorted_due.pop_front();
    if (out_sx !== pt.sx || out_sy !== pt.sy || out_end !== pt.last ||
        out_dropped !== pt.drop) begin
      errs++;
      $display("%0t: mismatch, exp x=%0d y=%0d end=%0b drop=%0b, got %0d %0d %0b %0b",
               $time, $signed(pt.sx), $signed(pt.sy), pt.last, pt.drop,
               $signed(out_sx), $signed(out_sy), out_end, out_dropped);
    end
  endtask

  initial begin
    set_fill     = 0;
    set_overflow = 1'b0;
    errs         = 0;
    seen         = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      set_fill     = 0;
      set_overflow = 1'b0;
      sorted_due.delete();
    end else begin
      // input first, so a same-cycle result still finds its expectation
      if (start && !busy) take_point(in_px, in_py, in_set_end);
      if (out_valid) check_result();
    end
    fail_count   <= errs;
    due_count    <= sorted_due.size();
    result_count <= seen;
  end

endmodule

### dv/tb_point_sorter_x_asc_y_desc_top.sv
module tb_point_sorter_x_asc_y_desc_top;

  localparam logic [31:0] C_MIN      = 32'h8000_0000;
  localparam logic [31:0] C_MAX      = 32'h7fff_ffff;
  localparam int          N_DIR      = 23;
  // random transactions, so that the whole run sends about 280
  localparam int          N_RANDOM   = 280 - N_DIR;
  // a full drain plus margin
  localparam int          DRAIN_WAIT = 4 * psort_pkg::MAX_POINTS + 16;

  // directed sets: single point, coordinate extremes, x ties with y ordering and a
  // duplicate, reversed x order, all points equal, y extremes on one x
  localparam logic [31:0] DIR_X [N_DIR] = '{
    32'd0,
    C_MAX, C_MIN, C_MIN, C_MAX, 32'd0, 32'hffff_ffff,
    32'd5, 32'd5, 32'd5, 32'd5, 32'd4, 32'd6,
    32'd3, 32'd2, 32'd1, 32'd0, 32'hffff_ffff,
    32'd7, 32'd7, 32'd7,
    32'd1, 32'd1
  };
  localparam logic [31:0] DIR_Y [N_DIR] = '{
    32'd0,
    C_MIN, C_MAX, C_MIN, C_MAX, 32'hffff_ffff, 32'd0,
    32'd1, 32'd3, 32'hffff_fffe, 32'd3, 32'd7, 32'hffff_fff7,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
    32'd7, 32'd7, 32'd7,
    C_MIN, C_MAX
  };
  localparam logic DIR_END [N_DIR] = '{
    1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b1,
    1'b0, 1'b1
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        start      = 1'b0;
  logic [31:0] in_px      = '0;
  logic [31:0] in_py      = '0;
  logic        in_set_end = 1'b0;
  logic        busy;
  logic        out_valid;
  logic [31:0] out_sx;
  logic [31:0] out_sy;
  logic        out_end;
  logic        out_dropped;

  // verdict inputs from the checker
  int fail_count;
  int due_count;
  int result_count;

  // stimulus bookkeeping
  int items_sent    = 0;
  int sets_sent     = 0;
  int overflow_sets = 0;
  int idle_pct      = 0;

  // 4 time unit period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  point_sorter_x_asc_y_desc_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_px       (in_px),
    .in_py       (in_py),
    .in_set_end  (in_set_end),
    .out_valid   (out_valid),
    .out_sx      (out_sx),
    .out_sy      (out_sy),
    .out_end     (out_end),
    .out_dropped (out_dropped)
  );

  point_sorter_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_px        (in_px),
    .in_py        (in_py),
    .in_set_end   (in_set_end),
    .out_valid    (out_valid),
    .out_sx       (out_sx),
    .out_sy       (out_sy),
    .out_end      (out_end),
    .out_dropped  (out_dropped),
    .fail_count   (fail_count),
    .due_count    (due_count),
    .result_count (result_count)
  );

  // mix of extremes, a narrow band around zero for ties, and full-range values
  function automatic logic [31:0] rand_coord();
    int band;
    band = $urandom_range(0, 6);
    case ($urandom_range(0, 9))
      0: begin
        return C_MIN;
      end
      1: begin
        return C_MAX;
      end
      2: begin
        return '0;
      end
      3, 4, 5: begin
        return band - 3;
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  // one input transaction; idle cycles first, each drawn at the idle rate, with
  // junk on the data ports while start is low; start stays high across busy
  // until the point is taken
  task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic last);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start      <= 1'b0;
      in_px      <= $urandom;
      in_py      <= $urandom;
      in_set_end <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
    start      <= 1'b1;
    in_px      <= x;
    in_py      <= y;
    in_set_end <= last;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // a whole set of random points, the last one marked
  task automatic send_set(input int size);
    for (int i = 0; i < size; i++) begin
      send_point(rand_coord(), rand_coord(), i == size - 1);
    end
    sets_sent++;
    if (size > psort_pkg::MAX_POINTS) overflow_sets++;
  endtask

  initial begin
    int rand_base;
    int done;
    int set_idx;
    int set_size;
    int guard;

    // reset at the start, once
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    idle_pct = 33;
    for (int i = 0; i < N_DIR; i++) begin
      send_point(DIR_X[i], DIR_Y[i], DIR_END[i]);
      if (DIR_END[i]) sets_sent++;
    end

    // random part: first two sets overflow (set_end dropped on a full store, and
    // a few extra points), then mostly small sets with the odd large or full one
    rand_base = items_sent;
    set_idx   = 0;
    while (items_sent - rand_base < N_RANDOM) begin
      done = items_sent - rand_base;
      // sender idles 33 percent, then 63, then never
      if (done < N_RANDOM / 3) idle_pct = 33;
      else if (done < 2 * N_RANDOM / 3) idle_pct = 63;
      else idle_pct = 0;
      case ($urandom_range(0, 19))
        0: begin
          set_size = $urandom_range(psort_pkg::MAX_POINTS + 1, psort_pkg::MAX_POINTS + 4);
        end
        1, 2: begin
          set_size = $urandom_range(psort_pkg::MAX_POINTS / 3, psort_pkg::MAX_POINTS);
        end
        3: begin
          set_size = psort_pkg::MAX_POINTS;
        end
        default: begin
          set_size = $urandom_range(1, 8);
        end
      endcase
      if (set_idx == 0) set_size = psort_pkg::MAX_POINTS + 1;
      if (set_idx == 1) set_size = psort_pkg::MAX_POINTS + 3;
      // last set is cut to what is left of the budget
      if (set_size > N_RANDOM - done) set_size = N_RANDOM - done;
      send_set(set_size);
      set_idx++;
    end
    start <= 1'b0;

    // let the last drain finish, bounded
    @(posedge clk);
    guard = 0;
    while (due_count != 0 && guard < DRAIN_WAIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);

    $display("run covered %0d transactions in %0d sets, %0d of them overflowing",
             items_sent, sets_sent, overflow_sets);
    $display("%0d sorted results checked, %0d still outstanding", result_count, due_count);
    if (fail_count == 0 && due_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
